### hdl/bctm_pkg.sv
// ---------------------------------------------------------------------------
// bctm_pkg
// types, codes and constants shared by the block cache tag manager
// ---------------------------------------------------------------------------
package bctm_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int OVERHEAD_DEFAULT = 32;
   localparam int SLOT_W           = 6;

   localparam logic [31:0]        MIN_FREE_RESET = 32'd4096;
   localparam logic signed [15:0] TEMP_MAX       = 16'sh7FFF;
   localparam logic signed [15:0] TEMP_MIN       = 16'sh8000;

   // commands
   localparam logic [2:0] CMD_READ       = 3'd0;
   localparam logic [2:0] CMD_WRITE_BACK = 3'd1;
   localparam logic [2:0] CMD_WRITE_THRU = 3'd2;
   localparam logic [2:0] CMD_SYNC       = 3'd3;
   localparam logic [2:0] CMD_DROP_CLEAN = 3'd4;
   localparam logic [2:0] CMD_DROP_DEV   = 3'd5;
   localparam logic [2:0] CMD_REDUCE     = 3'd6;
   localparam logic [2:0] CMD_UNKNOWN    = 3'd7;  // no such command

   // result kinds
   localparam logic [2:0] KIND_HIT       = 3'd0;
   localparam logic [2:0] KIND_ALLOC     = 3'd1;
   localparam logic [2:0] KIND_MISS      = 3'd2;
   localparam logic [2:0] KIND_WB        = 3'd3;
   localparam logic [2:0] KIND_DONE      = 3'd4;
   localparam logic [2:0] KIND_INVALID   = 3'd5;

   // datapath operations
   localparam logic [3:0] OP_NONE        = 4'd0;
   localparam logic [3:0] OP_LOAD        = 4'd1;
   localparam logic [3:0] OP_SCAN_LOOK   = 4'd2;
   localparam logic [3:0] OP_SCAN_SEL    = 4'd3;
   localparam logic [3:0] OP_SCAN_STAT   = 4'd4;
   localparam logic [3:0] OP_ACCESS      = 4'd5;
   localparam logic [3:0] OP_INVALID     = 4'd6;
   localparam logic [3:0] OP_DONE        = 4'd7;
   localparam logic [3:0] OP_SYNC_BEGIN  = 4'd8;
   localparam logic [3:0] OP_DROP_CLEAN  = 4'd9;
   localparam logic [3:0] OP_WB          = 4'd10;
   localparam logic [3:0] OP_SYNC_END    = 4'd11;
   localparam logic [3:0] OP_DEV_END     = 4'd12;
   localparam logic [3:0] OP_RED_FREE    = 4'd13;
   localparam logic [3:0] OP_RED_END     = 4'd14;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] device;
      logic [31:0] block_pos;
      logic [15:0] block_size;
      logic [31:0] free_bytes;
      logic [30:0] reduce_bytes;
   } req_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [SLOT_W-1:0] slot;
      logic [15:0]       wb_device;
      logic [31:0]       wb_block_pos;
      logic              device_write;
      logic              sync_due;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       bsz_zero;
      logic       scan_last;
      logic       best_found;
      logic       left_pos;
      logic       any_valid;
      logic       any_clean;
   } dp_stat_type;

endpackage

### hdl/bctm_ctl.sv
// ---------------------------------------------------------------------------
// bctm_ctl
// command sequencer: steps the datapath through scans and table updates
// ---------------------------------------------------------------------------
module bctm_ctl import bctm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_LOOK  = 4'd2;
   localparam logic [3:0] S_LDEC  = 4'd3;
   localparam logic [3:0] S_SEL   = 4'd4;
   localparam logic [3:0] S_SDEC  = 4'd5;
   localparam logic [3:0] S_STAT  = 4'd6;
   localparam logic [3:0] S_STDEC = 4'd7;
   localparam logic [3:0] S_RCHK  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       first_ff, first_in;

   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.cmd)
               CMD_READ, CMD_WRITE_BACK, CMD_WRITE_THRU: begin
                  if (stat.bsz_zero) begin
                     cmd.op   = OP_INVALID;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_LOOK;
                  end
               end
               CMD_SYNC: begin
                  cmd.op   = OP_SYNC_BEGIN;
                  state_in = S_SEL;
               end
               CMD_DROP_CLEAN: begin
                  cmd.op   = OP_DROP_CLEAN;
                  state_in = S_IDLE;
               end
               CMD_DROP_DEV: state_in = S_SEL;
               CMD_REDUCE: begin
                  first_in = 1'b1;
                  state_in = S_STAT;
               end
               default: begin
                  cmd.op   = OP_INVALID;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LOOK: begin
            cmd.op = OP_SCAN_LOOK;
            if (stat.scan_last) state_in = S_LDEC;
         end
         S_LDEC: begin
            cmd.op   = OP_ACCESS;
            state_in = S_IDLE;
         end
         S_SEL: begin
            cmd.op = OP_SCAN_SEL;
            if (stat.scan_last) state_in = S_SDEC;
         end
         S_SDEC: begin
            if (stat.best_found) begin
               if (stat.cmd == CMD_REDUCE) begin
                  cmd.op   = OP_RED_FREE;
                  state_in = S_RCHK;
               end else begin
                  cmd.op   = OP_WB;
                  state_in = S_SEL;
               end
            end else if (stat.cmd == CMD_SYNC) begin
               cmd.op   = OP_SYNC_END;
               state_in = S_IDLE;
            end else if (stat.cmd == CMD_DROP_DEV) begin
               cmd.op   = OP_DEV_END;
               state_in = S_IDLE;
            end else begin
               state_in = S_STAT;
            end
         end
         S_STAT: begin
            cmd.op = OP_SCAN_STAT;
            if (stat.scan_last) state_in = S_STDEC;
         end
         S_STDEC: begin
            first_in = 1'b0;
            if (first_ff && (!stat.any_valid || !stat.left_pos)) begin
               cmd.op   = OP_DONE;
               state_in = S_IDLE;
            end else if (!stat.any_clean) begin
               cmd.op   = OP_RED_END;
               state_in = S_IDLE;
            end else begin
               state_in = S_SEL;
            end
         end
         S_RCHK: begin
            if (!stat.left_pos) begin
               cmd.op   = OP_RED_END;
               state_in = S_IDLE;
            end else begin
               state_in = S_SEL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

### hdl/bctm_dp.sv
// ---------------------------------------------------------------------------
// bctm_dp
// tag table, slot scanner, byte budget and result register
// ---------------------------------------------------------------------------
module bctm_dp import bctm_pkg::*; #(
   parameter int DEPTH          = DEPTH_DEFAULT,
   parameter int ENTRY_OVERHEAD = OVERHEAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   input  req_type     req_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output dp_stat_type stat,
   output logic        rsp_strobe,
   output rsp_type     rsp_data
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // table
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic [DEPTH-1:0]        dirty_ff, dirty_in;
   logic signed [15:0]      temp_ff  [DEPTH];
   logic signed [15:0]      temp_in  [DEPTH];
   logic [15:0]             dev_ff   [DEPTH];
   logic [31:0]             pos_ff   [DEPTH];
   logic [15:0]             size_ff  [DEPTH];
   logic [31:0]             stamp_ff [DEPTH];
   logic                    alloc_we;
   logic [IDX_W-1:0]        alloc_slot;

   logic [31:0]             cnt_ff, cnt_in;
   logic                    sync_ff, sync_in;
   logic [31:0]             min_free_ff;
   req_type                 req_ff;
   logic signed [31:0]      left_ff, left_in;

   // scanner
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]        hit_slot_ff, hit_slot_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_W-1:0]        free_slot_ff, free_slot_in;
   logic                    best_found_ff, best_found_in;
   logic [IDX_W-1:0]        best_slot_ff, best_slot_in;
   logic [31:0]             best_age_ff, best_age_in;
   logic signed [15:0]      tmin_ff, tmin_in;
   logic                    any_valid_ff, any_valid_in;
   logic                    any_clean_ff, any_clean_in;
   logic                    any_dirty_ff, any_dirty_in;

   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    scanning, first, scan_last;
   logic                    ev, ed, dev_eq, pos_eq, pick, take;
   logic [31:0]             age;
   logic signed [15:0]      et;

   assign scanning  = (cmd.op == OP_SCAN_LOOK) || (cmd.op == OP_SCAN_SEL) ||
                      (cmd.op == OP_SCAN_STAT);
   assign first     = (idx_ff == '0);
   assign scan_last = (idx_ff == IDX_W'(DEPTH - 1));
   assign ev        = valid_ff[idx_ff];
   assign ed        = dirty_ff[idx_ff];
   assign et        = temp_ff[idx_ff];
   assign dev_eq    = (dev_ff[idx_ff] == req_ff.device);
   assign pos_eq    = (pos_ff[idx_ff] == req_ff.block_pos);
   assign age       = cnt_ff - stamp_ff[idx_ff];

   always_comb begin
      unique case (req_ff.command)
         CMD_SYNC:     pick = ev && ed;
         CMD_DROP_DEV: pick = ev && ed && dev_eq;
         CMD_REDUCE:   pick = ev && !ed && (et == tmin_ff);
         default:      pick = 1'b0;
      endcase
      take = pick && (first || !best_found_ff || (age < best_age_ff));
   end

   // scan accumulators
   always_comb begin
      idx_in        = idx_ff;
      hit_found_in  = hit_found_ff;
      hit_slot_in   = hit_slot_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      best_found_in = best_found_ff;
      best_slot_in  = best_slot_ff;
      best_age_in   = best_age_ff;
      tmin_in       = tmin_ff;
      any_valid_in  = any_valid_ff;
      any_clean_in  = any_clean_ff;
      any_dirty_in  = any_dirty_ff;
      if (scanning) begin
         idx_in = scan_last ? '0 : idx_ff + 1'b1;
      end
      if (cmd.op == OP_SCAN_LOOK) begin
         if (ev && dev_eq && pos_eq && (first || !hit_found_ff)) begin
            hit_found_in = 1'b1;
            hit_slot_in  = idx_ff;
         end else if (first) begin
            hit_found_in = 1'b0;
         end
         if (!ev && (first || !free_found_ff)) begin
            free_found_in = 1'b1;
            free_slot_in  = idx_ff;
         end else if (first) begin
            free_found_in = 1'b0;
         end
      end
      if (cmd.op == OP_SCAN_SEL) begin
         if (take) begin
            best_found_in = 1'b1;
            best_slot_in  = idx_ff;
            best_age_in   = age;
         end else if (first) begin
            best_found_in = 1'b0;
         end
      end
      if (cmd.op == OP_SCAN_STAT) begin
         any_valid_in = (!first && any_valid_ff) || ev;
         any_dirty_in = (!first && any_dirty_ff) || (ev && ed);
         any_clean_in = (!first && any_clean_ff) || (ev && !ed);
         if (ev && !ed && (first || !any_clean_ff || (et < tmin_ff))) tmin_in = et;
      end
   end

   // table updates and results
   always_comb begin
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      temp_in       = temp_ff;
      cnt_in        = cnt_ff;
      sync_in       = sync_ff;
      left_in       = left_ff;
      alloc_we      = 1'b0;
      alloc_slot    = free_slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      rsp_in.last   = 1'b1;
      unique case (cmd.op)
         OP_LOAD: left_in = signed'({1'b0, req_data.reduce_bytes});
         OP_ACCESS: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.wb_device     = req_ff.device;
            rsp_in.wb_block_pos  = req_ff.block_pos;
            rsp_in.device_write  = (req_ff.command == CMD_WRITE_THRU);
            if (hit_found_ff) begin
               rsp_in.kind = KIND_HIT;
               rsp_in.slot = SLOT_W'(hit_slot_ff);
               if (temp_ff[hit_slot_ff] != TEMP_MAX)
                  temp_in[hit_slot_ff] = temp_ff[hit_slot_ff] + 16'sd1;
               if (req_ff.command != CMD_READ) dirty_in[hit_slot_ff] = 1'b1;
            end else if (free_found_ff && (req_ff.free_bytes >= min_free_ff)) begin
               rsp_in.kind           = KIND_ALLOC;
               rsp_in.slot           = SLOT_W'(free_slot_ff);
               alloc_we              = 1'b1;
               valid_in[free_slot_ff] = 1'b1;
               dirty_in[free_slot_ff] = (req_ff.command != CMD_READ);
               temp_in[free_slot_ff]  = (req_ff.command != CMD_READ) ? 16'sd1 : 16'sd0;
               cnt_in                = cnt_ff + 32'd1;
            end else begin
               rsp_in.kind          = KIND_MISS;
               rsp_in.device_write  = (req_ff.command != CMD_READ);
            end
         end
         OP_INVALID: begin
            rsp_strobe_in = 1'b1;
            rsp_in.kind   = KIND_INVALID;
         end
         OP_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_in.kind   = KIND_DONE;
         end
         OP_SYNC_BEGIN: sync_in = 1'b0;
         OP_DROP_CLEAN: begin
            valid_in      = valid_ff & dirty_ff;
            rsp_strobe_in = 1'b1;
            rsp_in.kind   = KIND_DONE;
         end
         OP_WB: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.kind          = KIND_WB;
            rsp_in.slot          = SLOT_W'(best_slot_ff);
            rsp_in.wb_device     = dev_ff[best_slot_ff];
            rsp_in.wb_block_pos  = pos_ff[best_slot_ff];
            rsp_in.device_write  = 1'b1;
            rsp_in.last          = 1'b0;
            dirty_in[best_slot_ff] = 1'b0;
         end
         OP_SYNC_END: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (valid_ff[i] && (temp_ff[i] != TEMP_MIN)) temp_in[i] = temp_ff[i] - 16'sd1;
            end
            rsp_strobe_in = 1'b1;
            rsp_in.kind   = KIND_DONE;
         end
         OP_DEV_END: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (dev_ff[i] == req_ff.device) valid_in[i] = 1'b0;
            end
            rsp_strobe_in = 1'b1;
            rsp_in.kind   = KIND_DONE;
         end
         OP_RED_FREE: begin
            valid_in[best_slot_ff] = 1'b0;
            left_in = left_ff - signed'(32'({16'b0, size_ff[best_slot_ff]}) +
                                        32'(ENTRY_OVERHEAD));
         end
         OP_RED_END: begin
            sync_in       = (left_ff > 0) && any_dirty_ff;
            rsp_strobe_in = 1'b1;
            rsp_in.kind   = KIND_DONE;
         end
         default: ;
      endcase
      rsp_in.sync_due = sync_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         dirty_ff      <= '0;
         cnt_ff        <= '0;
         sync_ff       <= 1'b0;
         min_free_ff   <= MIN_FREE_RESET;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         cnt_ff        <= cnt_in;
         sync_ff       <= sync_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) min_free_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff       <= temp_in;
      left_ff       <= left_in;
      hit_found_ff  <= hit_found_in;
      hit_slot_ff   <= hit_slot_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      best_found_ff <= best_found_in;
      best_slot_ff  <= best_slot_in;
      best_age_ff   <= best_age_in;
      tmin_ff       <= tmin_in;
      any_valid_ff  <= any_valid_in;
      any_clean_ff  <= any_clean_in;
      any_dirty_ff  <= any_dirty_in;
      rsp_ff        <= rsp_in;
      if (cmd.op == OP_LOAD) req_ff <= req_data;
      if (alloc_we) begin
         dev_ff[alloc_slot]   <= req_ff.device;
         pos_ff[alloc_slot]   <= req_ff.block_pos;
         size_ff[alloc_slot]  <= req_ff.block_size;
         stamp_ff[alloc_slot] <= cnt_ff;
      end
   end

   assign stat.cmd        = req_ff.command;
   assign stat.bsz_zero   = (req_ff.block_size == 16'd0);
   assign stat.scan_last  = scan_last;
   assign stat.best_found = best_found_ff;
   assign stat.left_pos   = (left_ff > 0);
   assign stat.any_valid  = any_valid_ff;
   assign stat.any_clean  = any_clean_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### hdl/block_cache_tag_manager_top.sv
// ---------------------------------------------------------------------------
// block_cache_tag_manager_top
// tag table of cached disk blocks with least-frequently-used eviction
// ---------------------------------------------------------------------------
// usage
//   command channel: drive req_data and raise start; the word is taken at a
//   clock edge where start is high and busy is low. busy stays high until
//   the last result word has been issued
//   result channel: each word sits on rsp_data for one cycle with rsp_strobe
//   high; rsp_data.last marks the final word of a command. the receiver
//   cannot stall, results are simply presented
//   csr port: csr_wr_en writes csr_wr_data to min_free_bytes; the user
//   writes only while idle, the block itself does not enforce this
//   every table walk visits one slot per cycle
//     read / write     one lookup walk, one result
//     drop clean       no walk, as for a zero size or unknown command
//     sync, drop dev   one select walk per writeback plus a final one
//     reduce           a stat walk per level, a select walk per freed tag
//   throughput is one command at a time, set by the single slot scanner
//   reset: table empty, stamp counter and sync flag zero, threshold 4096
// ---------------------------------------------------------------------------
module block_cache_tag_manager_top import bctm_pkg::*; #(
   parameter int DEPTH          = DEPTH_DEFAULT,
   parameter int ENTRY_OVERHEAD = OVERHEAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   // sequencer
   bctm_ctl u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (dp_stat),
      .cmd   (ctl_cmd)
   );

   // table and scanner
   bctm_dp #(
      .DEPTH          (DEPTH),
      .ENTRY_OVERHEAD (ENTRY_OVERHEAD)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ctl_cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (dp_stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

   // a word taken in never produces a result in the next cycle
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result right after command accept");

   // more words pending keeps the block busy
   a_busy_mid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("idle while results pending");

   // the final word arrives once the sequencer is back idle
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |-> !busy)
      else $error("busy after last result");

endmodule

### bench/block_cache_tag_manager_checker.sv
// ---------------------------------------------------------------------------
// block_cache_tag_manager_checker
// watches the command, result and csr ports, keeps its own copy of the tag
// table and compares every result word with the predicted one
// ---------------------------------------------------------------------------
module block_cache_tag_manager_checker import bctm_pkg::*; #(
   parameter int DEPTH          = DEPTH_DEFAULT,
   parameter int ENTRY_OVERHEAD = OVERHEAD_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_strobe,
   input  rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          fail_count
);

   logic [31:0]        threshold;
   logic               tag_valid [DEPTH];
   logic [15:0]        tag_dev   [DEPTH];
   logic [31:0]        tag_pos   [DEPTH];
   logic [15:0]        tag_size  [DEPTH];
   logic signed [15:0] tag_temp  [DEPTH];
   logic               tag_dirty [DEPTH];
   logic [31:0]        tag_stamp [DEPTH];
   logic [31:0]        stamp_next;
   logic               sync_pending;

   rsp_type pending_words [$];
   rsp_type burst [$];
   int      mismatches;

   // valid slots sorted newest first, ties to the lower slot
   function automatic int newest_first(output int ord [DEPTH]);
      int n;
      int j;
      n = 0;
      for (int i = 0; i < DEPTH; i++) begin
         if (!tag_valid[i]) continue;
         j = n;
         while (j > 0 && (stamp_next - tag_stamp[ord[j-1]]) > (stamp_next - tag_stamp[i])) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = i;
         n++;
      end
      return n;
   endfunction

   task automatic table_stats(output int cold, output int cold_cnt, output int ndirty,
                              output int nvalid);
      cold = 32'h7FFF_FFFF;
      cold_cnt = 0;
      ndirty = 0;
      nvalid = 0;
      for (int i = 0; i < DEPTH; i++) begin
         if (!tag_valid[i]) continue;
         if (!tag_dirty[i]) begin
            if (int'(tag_temp[i]) < cold) begin
               cold = tag_temp[i];
               cold_cnt = 1;
            end else if (int'(tag_temp[i]) == cold) begin
               cold_cnt++;
            end
         end else begin
            ndirty++;
         end
         nvalid++;
      end
   endtask

   task automatic add_word(logic [2:0] kind, int slot, logic [15:0] dev, logic [31:0] pos,
                           logic dw);
      rsp_type w;
      w = '0;
      w.kind = kind;
      w.slot = slot[SLOT_W-1:0];
      w.wb_device = dev;
      w.wb_block_pos = pos;
      w.device_write = dw;
      burst.push_back(w);
   endtask

   task automatic warm_tag(int s);
      if (tag_temp[s] != TEMP_MAX) tag_temp[s] = tag_temp[s] + 16'sd1;
   endtask

   task automatic predict_command(req_type r);
      int    ord [DEPTH];
      int    cnt;
      int    s;
      int    cold, cold_cnt, ndirty, nvalid;
      longint budget;
      rsp_type w;
      burst.delete();
      budget = r.reduce_bytes;
      case (r.command)
         CMD_READ, CMD_WRITE_BACK, CMD_WRITE_THRU: begin
            if (r.block_size == 0) begin
               add_word(KIND_INVALID, 0, '0, '0, 1'b0);
            end else begin
               s = -1;
               for (int i = 0; i < DEPTH; i++)
                  if (s < 0 && tag_valid[i] && tag_dev[i] == r.device && tag_pos[i] == r.block_pos)
                     s = i;
               if (s >= 0) begin
                  warm_tag(s);
                  if (r.command != CMD_READ) tag_dirty[s] = 1'b1;
                  add_word(KIND_HIT, s, r.device, r.block_pos, r.command == CMD_WRITE_THRU);
               end else begin
                  if (r.free_bytes >= threshold)
                     for (int i = 0; i < DEPTH; i++)
                        if (s < 0 && !tag_valid[i]) s = i;
                  if (s >= 0) begin
                     tag_valid[s] = 1'b1;
                     tag_dev[s]   = r.device;
                     tag_pos[s]   = r.block_pos;
                     tag_size[s]  = r.block_size;
                     tag_temp[s]  = '0;
                     tag_dirty[s] = 1'b0;
                     tag_stamp[s] = stamp_next;
                     stamp_next++;
                     if (r.command != CMD_READ) begin
                        tag_dirty[s] = 1'b1;
                        warm_tag(s);
                     end
                     add_word(KIND_ALLOC, s, r.device, r.block_pos,
                              r.command == CMD_WRITE_THRU);
                  end else begin
                     add_word(KIND_MISS, 0, r.device, r.block_pos, r.command != CMD_READ);
                  end
               end
            end
         end
         CMD_SYNC: begin
            cnt = newest_first(ord);
            for (int k = 0; k < cnt; k++) begin
               s = ord[k];
               if (tag_dirty[s]) begin
                  add_word(KIND_WB, s, tag_dev[s], tag_pos[s], 1'b1);
                  tag_dirty[s] = 1'b0;
               end
               if (tag_temp[s] != TEMP_MIN) tag_temp[s] = tag_temp[s] - 16'sd1;
            end
            sync_pending = 1'b0;
            add_word(KIND_DONE, 0, '0, '0, 1'b0);
         end
         CMD_DROP_CLEAN: begin
            for (int i = 0; i < DEPTH; i++)
               if (tag_valid[i] && !tag_dirty[i]) tag_valid[i] = 1'b0;
            add_word(KIND_DONE, 0, '0, '0, 1'b0);
         end
         CMD_DROP_DEV: begin
            cnt = newest_first(ord);
            for (int k = 0; k < cnt; k++) begin
               s = ord[k];
               if (tag_dev[s] != r.device) continue;
               if (tag_dirty[s]) begin
                  add_word(KIND_WB, s, tag_dev[s], tag_pos[s], 1'b1);
                  tag_dirty[s] = 1'b0;
               end
               tag_valid[s] = 1'b0;
            end
            add_word(KIND_DONE, 0, '0, '0, 1'b0);
         end
         CMD_REDUCE: begin
            table_stats(cold, cold_cnt, ndirty, nvalid);
            if (nvalid > 0 && budget > 0) begin
               // free the coldest clean tags level by level
               while (budget > 0 && ndirty < nvalid) begin
                  cnt = newest_first(ord);
                  for (int k = 0; k < cnt && cold_cnt > 0 && budget > 0; k++) begin
                     s = ord[k];
                     if (tag_valid[s] && !tag_dirty[s] && int'(tag_temp[s]) == cold) begin
                        budget -= longint'(tag_size[s]) + ENTRY_OVERHEAD;
                        tag_valid[s] = 1'b0;
                        cold_cnt--;
                     end
                  end
                  if (budget > 0) table_stats(cold, cold_cnt, ndirty, nvalid);
               end
               sync_pending = budget > 0 && ndirty > 0;
            end
            add_word(KIND_DONE, 0, '0, '0, 1'b0);
         end
         default: add_word(KIND_INVALID, 0, '0, '0, 1'b0);
      endcase
      foreach (burst[k]) begin
         w = burst[k];
         w.sync_due = sync_pending;
         w.last = (k == burst.size() - 1);
         pending_words.push_back(w);
      end
   endtask

   task automatic compare_word(rsp_type got);
      rsp_type want;
      if (pending_words.size() == 0) begin
         $error("unexpected result word kind=%0d slot=%0d", got.kind, got.slot);
         mismatches++;
         return;
      end
      want = pending_words.pop_front();
      if (got.kind != want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, got.kind); mismatches++;
      end
      if (got.slot != want.slot) begin
         $error("slot: expected %0d, got %0d", want.slot, got.slot); mismatches++;
      end
      if (got.wb_device != want.wb_device) begin
         $error("wb_device: expected %h, got %h", want.wb_device, got.wb_device); mismatches++;
      end
      if (got.wb_block_pos != want.wb_block_pos) begin
         $error("wb_block_pos: expected %h, got %h", want.wb_block_pos, got.wb_block_pos);
         mismatches++;
      end
      if (got.device_write != want.device_write) begin
         $error("device_write: expected %b, got %b", want.device_write, got.device_write);
         mismatches++;
      end
      if (got.sync_due != want.sync_due) begin
         $error("sync_due: expected %b, got %b", want.sync_due, got.sync_due);
         mismatches++;
      end
      if (got.last != want.last) begin
         $error("last: expected %b, got %b", want.last, got.last); mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mismatches = 0;
         threshold = MIN_FREE_RESET;
         for (int i = 0; i < DEPTH; i++) begin
            tag_valid[i] = 1'b0;
            tag_dirty[i] = 1'b0;
            tag_temp[i]  = '0;
            tag_dev[i]   = '0;
            tag_pos[i]   = '0;
            tag_size[i]  = '0;
            tag_stamp[i] = '0;
         end
         stamp_next = '0;
         sync_pending = 1'b0;
         pending_words.delete();
      end else begin
         if (rsp_strobe) compare_word(rsp_data);
         if (csr_wr_en) threshold = csr_wr_data;
         if (start && !busy) predict_command(req_data);
      end
      fail_count <= mismatches + pending_words.size();
   end

endmodule

### bench/tb_block_cache_tag_manager_top.sv
// ---------------------------------------------------------------------------
// tb_block_cache_tag_manager_top
// drives commands and threshold writes into the tag manager; a checker beside
// the block predicts and compares every result word, this top gives the verdict
// ---------------------------------------------------------------------------
module tb_block_cache_tag_manager_top;
   import bctm_pkg::*;

   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int RANDOM_WORDS = 400;
   localparam int CALM_TAIL    = 60;    // last words go without idle gaps
   localparam int SETTLE       = 60;    // longer than any walk that ends without a result
   localparam int COLD_SYNCS   = 8;     // a few syncs to cool a tag below zero

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   int          fail_count;
   int          cycle_count;
   logic        idle_on;

   block_cache_tag_manager_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   block_cache_tag_manager_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // hold start high until the block takes the word; returns at the accepting edge
   task automatic send_word(req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // random idle burst between words, none when idling is off
   task automatic maybe_idle();
      if (idle_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // drain everything in flight, then let trailing walks finish
   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (busy);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_threshold(logic [31:0] value);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_word(logic [2:0] cmd, logic [15:0] dev, logic [31:0] pos,
                                         logic [15:0] bsz, logic [31:0] freeb,
                                         logic [30:0] budget);
      req_type r;
      r.command = cmd;
      r.device = dev;
      r.block_pos = pos;
      r.block_size = bsz;
      r.free_bytes = freeb;
      r.reduce_bytes = budget;
      return r;
   endfunction

   // random word: mostly lookups on a small key pool so hits and refills happen
   function automatic req_type random_word();
      req_type r;
      int      pick;
      r.device = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0) r.device = 16'hFFFF;
      r.block_pos = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 7));
      if ($urandom_range(0, 29) == 0) r.block_pos = 32'hFFFF_FFFF;
      r.block_size = ($urandom_range(0, 29) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
      r.free_bytes = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 8191)) : $urandom;
      pick = $urandom_range(0, 99);
      r.reduce_bytes = (pick < 10) ? '0 :
                       (pick < 80) ? 31'($urandom_range(1, 70000)) :
                       (pick < 95) ? 31'($urandom) : 31'h7FFF_FFFF;
      pick = $urandom_range(0, 99);
      r.command = (pick < 30) ? CMD_READ :
                  (pick < 50) ? CMD_WRITE_BACK :
                  (pick < 65) ? CMD_WRITE_THRU :
                  (pick < 74) ? CMD_SYNC :
                  (pick < 80) ? CMD_DROP_CLEAN :
                  (pick < 88) ? CMD_DROP_DEV :
                  (pick < 98) ? CMD_REDUCE : CMD_UNKNOWN;
      return r;
   endfunction

   initial begin
      cycle_count = 0;
      idle_on = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: lookups at reset threshold, edges of every field
      send_word(make_word(CMD_READ, 16'h0000, 32'h0, 16'd512, 32'd4096, '0));       // alloc
      send_word(make_word(CMD_READ, 16'h0000, 32'h0, 16'd512, 32'd0, '0));          // hit
      send_word(make_word(CMD_WRITE_BACK, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF,
                          32'hFFFF_FFFF, 31'h7FFF_FFFF));
      send_word(make_word(CMD_WRITE_THRU, 16'h0000, 32'h0, 16'd1, 32'd0, '0));     // hit thru
      send_word(make_word(CMD_WRITE_BACK, 16'h0001, 32'h5, 16'd64, 32'd4095, '0));  // not cached
      send_word(make_word(CMD_WRITE_THRU, 16'h0001, 32'h6, 16'd64, 32'd4095, '0));  // not cached
      send_word(make_word(CMD_READ, 16'h0001, 32'h7, 16'd0, 32'hFFFF_FFFF, '0));     // zero size
      send_word(make_word(CMD_UNKNOWN, 16'h0001, 32'h7, 16'd8, 32'hFFFF_FFFF, '0));  // unknown
      send_word(make_word(CMD_REDUCE, '0, '0, '0, '0, '0));                          // zero budget
      send_word(make_word(CMD_SYNC, '0, '0, '0, '0, '0));
      send_word(make_word(CMD_DROP_DEV, 16'hFFFF, '0, '0, '0, '0));
      send_word(make_word(CMD_DROP_CLEAN, '0, '0, '0, '0, '0));
      send_word(make_word(CMD_REDUCE, '0, '0, '0, '0, 31'd100));                     // empty table
      // fill the table with dirty tags, one more misses, then reduce cannot help
      for (int i = 0; i < 17; i++)
         send_word(make_word(CMD_WRITE_BACK, 16'h0002, 32'(i), 16'(100 + i), 32'hFFFF_FFFF,
                             '0));
      send_word(make_word(CMD_REDUCE, '0, '0, '0, '0, 31'h7FFF_FFFF));               // sync needed
      send_word(make_word(CMD_SYNC, '0, '0, '0, '0, '0));                            // all written back
      send_word(make_word(CMD_REDUCE, '0, '0, '0, '0, 31'd300));                     // partial free
      send_word(make_word(CMD_DROP_DEV, 16'h0002, '0, '0, '0, '0));

      // one clean tag cooled below zero, then read again
      send_word(make_word(CMD_READ, 16'h0003, 32'h9, 16'd32, 32'hFFFF_FFFF, '0));
      idle_on = 1'b0;
      for (int i = 0; i < COLD_SYNCS; i++)
         send_word(make_word(CMD_SYNC, '0, '0, '0, '0, '0));
      send_word(make_word(CMD_READ, 16'h0003, 32'h9, 16'd32, 32'hFFFF_FFFF, '0));
      idle_on = 1'b1;

      // random phases under several thresholds, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_threshold(32'd0);
            1: write_threshold(32'hFFFF_FFFF);
            2: write_threshold($urandom);
            3: write_threshold(32'h0000_1000);
            default: write_threshold(32'h5555_AAAA);
         endcase
         for (int i = 0; i < RANDOM_WORDS / 5; i++) begin
            if (ph == 4 && i >= RANDOM_WORDS / 5 - CALM_TAIL) idle_on = 1'b0;
            send_word(random_word());
            maybe_idle();
         end
      end

      wait_quiet();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### files.f
hdl/bctm_pkg.sv
hdl/bctm_ctl.sv
hdl/bctm_dp.sv
hdl/block_cache_tag_manager_top.sv
bench/block_cache_tag_manager_checker.sv
bench/tb_block_cache_tag_manager_top.sv
